// ===== rtl/core/scfw_pkg.sv =====
// ----------------------------------------------------------------------------
// scfw_pkg
// Shared widths, operation codes and defaults of the sector cache directory.
// ----------------------------------------------------------------------------
package scfw_pkg;

   localparam int unsigned ENTRIES_DEF = 64;
   localparam int unsigned SLOT_W      = 6;
   localparam int unsigned SECTOR_W    = 32;
   localparam int unsigned OP_W        = 2;

   localparam logic [OP_W-1:0] OP_READ  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_SEARCH    = 6'b000010,
      ST_EVICT     = 6'b000100,
      ST_FLUSH_SCAN = 6'b001000,
      ST_FLUSH_RD  = 6'b010000,
      ST_RESP      = 6'b100000
   } state_type;

endpackage

// ===== rtl/core/sector_cache_fifo_writeback.sv =====
// ----------------------------------------------------------------------------
// sector_cache_fifo_writeback
// Fully associative sector cache directory with FIFO replacement and
// write-back dirty tracking; one tag comparator walks the tag memory.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | operation, sector
//  rsp     | out       | rsp_valid/rsp_stall | hit, slot, fill, writeback,
//          |           |                     | writeback_sector, last
//
//  read/write: up to one tag memory read per filled entry, plus an eviction
//    step when a full cache misses
//  flush: scans up to ENTRIES slots from the oldest; each dirty entry is read and returned
//  req_stall is high from acceptance until the last result is taken
//  a stalled result holds its register and pauses the flush walk
//  reset clears dirty marks, fill count and oldest slot; tags need no clear
module sector_cache_fifo_writeback
   import scfw_pkg::*;
#(
   parameter int unsigned ENTRIES = ENTRIES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [SECTOR_W-1:0] req_sector,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_hit,
   output logic [SLOT_W-1:0]   rsp_slot,
   output logic                rsp_fill,
   output logic                rsp_writeback,
   output logic [SECTOR_W-1:0] rsp_writeback_sector,
   output logic                rsp_last
);

   localparam int unsigned IDX_W = $clog2(ENTRIES);
   localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

   state_type            state_ff, state_in;
   logic [OP_W-1:0]      op_ff, op_in;
   logic [SECTOR_W-1:0]  sector_ff, sector_in;
   logic [ENTRIES-1:0]   dirty_ff, dirty_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     oldest_ff, oldest_in;
   logic [CNT_W-1:0]     iss_ff, iss_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic [IDX_W-1:0]     ptr_ff, ptr_in;

   logic                 hit_ff, hit_in;
   logic [IDX_W-1:0]     slot_ff, slot_in;
   logic                 fill_ff, fill_in;
   logic                 wb_ff, wb_in;
   logic [SECTOR_W-1:0]  wbs_ff, wbs_in;
   logic                 last_ff, last_in;

   logic [SECTOR_W-1:0]  tag_mem_ff [ENTRIES];
   logic [SECTOR_W-1:0]  rd_data_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;

   logic                 req_take;
   logic                 tag_match;
   logic                 full;
   logic [ENTRIES-1:0]   ptr_bit;
   logic [IDX_W-1:0]     ptr_next;
   logic [IDX_W-1:0]     oldest_next;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_RESP);

   assign rsp_hit              = hit_ff;
   assign rsp_slot             = SLOT_W'(slot_ff);
   assign rsp_fill             = fill_ff;
   assign rsp_writeback        = wb_ff;
   assign rsp_writeback_sector = wbs_ff;
   assign rsp_last             = last_ff;

   assign tag_match   = cmp_vld_ff && (rd_data_ff == sector_ff);
   assign full        = (count_ff == CNT_W'(ENTRIES));
   assign ptr_bit     = {{(ENTRIES-1){1'b0}}, 1'b1} << ptr_ff;
   assign ptr_next    = (ptr_ff == IDX_W'(ENTRIES - 1)) ? '0 : ptr_ff + 1'b1;
   assign oldest_next = (oldest_ff == IDX_W'(ENTRIES - 1)) ? '0 : oldest_ff + 1'b1;

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      sector_in  = sector_ff;
      dirty_in   = dirty_ff;
      count_in   = count_ff;
      oldest_in  = oldest_ff;
      iss_in     = iss_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      ptr_in     = ptr_ff;
      hit_in     = hit_ff;
      slot_in    = slot_ff;
      fill_in    = fill_ff;
      wb_in      = wb_ff;
      wbs_in     = wbs_ff;
      last_in    = last_ff;
      rd_addr    = ptr_ff;
      wr_en      = 1'b0;
      wr_addr    = oldest_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               op_in     = req_operation;
               sector_in = req_sector;
               iss_in    = '0;
               ptr_in    = oldest_ff;
               if (req_operation == OP_READ || req_operation == OP_WRITE) begin
                  state_in = ST_SEARCH;
               end else if (req_operation == OP_FLUSH) begin
                  if (dirty_ff == '0) begin
                     hit_in   = 1'b0;
                     slot_in  = '0;
                     fill_in  = 1'b0;
                     wb_in    = 1'b0;
                     wbs_in   = '0;
                     last_in  = 1'b1;
                     state_in = ST_RESP;
                  end else begin
                     state_in = ST_FLUSH_SCAN;
                  end
               end
            end
         end

         ST_SEARCH: begin
            if (tag_match) begin
               if (op_ff == OP_WRITE) begin
                  dirty_in[cmp_idx_ff] = 1'b1;
               end
               hit_in   = 1'b1;
               slot_in  = cmp_idx_ff;
               fill_in  = 1'b0;
               wb_in    = 1'b0;
               wbs_in   = '0;
               last_in  = 1'b1;
               state_in = ST_RESP;
            end else if (iss_ff < count_ff) begin
               rd_addr    = iss_ff[IDX_W-1:0];
               cmp_vld_in = 1'b1;
               cmp_idx_in = iss_ff[IDX_W-1:0];
               iss_in     = iss_ff + 1'b1;
            end else if (!cmp_vld_ff) begin
               if (!full) begin
                  wr_en    = 1'b1;
                  wr_addr  = count_ff[IDX_W-1:0];
                  dirty_in[count_ff[IDX_W-1:0]] = (op_ff == OP_WRITE);
                  count_in = count_ff + 1'b1;
                  hit_in   = 1'b0;
                  slot_in  = count_ff[IDX_W-1:0];
                  fill_in  = 1'b1;
                  wb_in    = 1'b0;
                  wbs_in   = '0;
                  last_in  = 1'b1;
                  state_in = ST_RESP;
               end else begin
                  rd_addr  = oldest_ff;
                  state_in = ST_EVICT;
               end
            end
         end

         ST_EVICT: begin
            wr_en     = 1'b1;
            wr_addr   = oldest_ff;
            hit_in    = 1'b0;
            slot_in   = oldest_ff;
            fill_in   = 1'b1;
            wb_in     = dirty_ff[oldest_ff];
            wbs_in    = dirty_ff[oldest_ff] ? rd_data_ff : '0;
            last_in   = 1'b1;
            dirty_in[oldest_ff] = (op_ff == OP_WRITE);
            oldest_in = oldest_next;
            state_in  = ST_RESP;
         end

         ST_FLUSH_SCAN: begin
            rd_addr = ptr_ff;
            if (dirty_ff[ptr_ff]) begin
               state_in = ST_FLUSH_RD;
            end else begin
               ptr_in = ptr_next;
            end
         end

         ST_FLUSH_RD: begin
            hit_in   = 1'b0;
            slot_in  = ptr_ff;
            fill_in  = 1'b0;
            wb_in    = 1'b1;
            wbs_in   = rd_data_ff;
            last_in  = ((dirty_ff & ~ptr_bit) == '0);
            dirty_in[ptr_ff] = 1'b0;
            ptr_in   = ptr_next;
            state_in = ST_RESP;
         end

         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = last_ff ? ST_IDLE : ST_FLUSH_SCAN;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         dirty_ff   <= '0;
         count_ff   <= '0;
         oldest_ff  <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         dirty_ff   <= dirty_in;
         count_ff   <= count_in;
         oldest_ff  <= oldest_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      sector_ff  <= sector_in;
      iss_ff     <= iss_in;
      cmp_idx_ff <= cmp_idx_in;
      ptr_ff     <= ptr_in;
      hit_ff     <= hit_in;
      slot_ff    <= slot_in;
      fill_ff    <= fill_in;
      wb_ff      <= wb_in;
      wbs_ff     <= wbs_in;
      last_ff    <= last_in;
   end

   // tag memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         tag_mem_ff[wr_addr] <= sector_ff;
      end
      rd_data_ff <= tag_mem_ff[rd_addr];
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("fill count above entry count");

   a_oldest_idle : assert property (@(posedge clock) disable iff (reset)
      !full |-> oldest_ff == '0)
      else $error("oldest slot moved before cache filled");

   a_dirty_valid : assert property (@(posedge clock) disable iff (reset)
      !full |-> (dirty_ff >> count_ff) == '0)
      else $error("dirty mark on an unused slot");

   a_hit_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_fill && !rsp_writeback)
      else $error("hit transaction orders a fill or writeback");

   a_flush_clear : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_writeback && !rsp_fill |-> !dirty_ff[slot_ff])
      else $error("flushed slot still marked dirty");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Checks the sector cache directory against a behavioral copy of its tag
// store, dirty marks and FIFO order. A short stimulus table goes through
// the empty cache, hits, misses, writes and flushes. Random reads, writes
// and flushes over a pool of recent sectors then fill the cache and evict
// from it. Both channels see random idle and stall cycles, one long
// receiver hold-off and one pause until every result has come back.
// ----------------------------------------------------------------------------
module tb_top
   import scfw_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned N_SLOTS = ENTRIES_DEF;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int unsigned N_DIR = 21;
   localparam int unsigned RAND_ITEMS = 400;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned POOL_DEPTH = 96;

   typedef struct packed {
      logic                hit;
      logic [SLOT_W-1:0]   slot;
      logic                fill;
      logic                writeback;
      logic [SECTOR_W-1:0] writeback_sector;
      logic                last;
   } cache_rsp_type;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [SECTOR_W-1:0] sector;
      logic                typed;
      cache_rsp_type       want;
   } stim_row_type;

   localparam cache_rsp_type NO_RSP = '0;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_operation = OP_READ;
   logic [SECTOR_W-1:0] req_sector = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_hit;
   logic [SLOT_W-1:0]   rsp_slot;
   logic                rsp_fill;
   logic                rsp_writeback;
   logic [SECTOR_W-1:0] rsp_writeback_sector;
   logic                rsp_last;

   // expected transactions of the result channel, oldest first
   cache_rsp_type       rsp_q[$];
   cache_rsp_type       got_rsp;
   cache_rsp_type       want_rsp;
   int unsigned         mismatches = 0;

   // shadow directory
   logic [SECTOR_W-1:0] tag_mem [N_SLOTS];
   bit                  dirty_mark [N_SLOTS];
   int unsigned         cached = 0;
   int unsigned         oldest = 0;

   logic [SECTOR_W-1:0] recent_sectors[$];
   bit                  quiet = 1'b0;
   bit                  hold_rsp = 1'b0;

   stim_row_type dir_tab [0:N_DIR-1] = '{
      // empty flush after reset
      {OP_FLUSH,  32'h0000_0000, 1'b1, {1'b0, 6'd0, 1'b0, 1'b0, 32'h0, 1'b1}},
      {OP_READ,   32'h0000_0000, 1'b1, {1'b0, 6'd0, 1'b1, 1'b0, 32'h0, 1'b1}},
      {OP_WRITE,  32'hFFFF_FFFF, 1'b1, {1'b0, 6'd1, 1'b1, 1'b0, 32'h0, 1'b1}},
      {OP_READ,   32'hFFFF_FFFF, 1'b1, {1'b1, 6'd1, 1'b0, 1'b0, 32'h0, 1'b1}},
      {OP_UNUSED, 32'h1234_5678, 1'b0, NO_RSP},
      {OP_WRITE,  32'h0000_0000, 1'b1, {1'b1, 6'd0, 1'b0, 1'b0, 32'h0, 1'b1}},
      {OP_FLUSH,  32'h0000_0000, 1'b0, NO_RSP},
      {OP_FLUSH,  32'hFFFF_FFFF, 1'b1, {1'b0, 6'd0, 1'b0, 1'b0, 32'h0, 1'b1}},
      {OP_WRITE,  32'h8000_0000, 1'b0, NO_RSP},
      {OP_WRITE,  32'h0000_0001, 1'b0, NO_RSP},
      {OP_READ,   32'h8000_0000, 1'b0, NO_RSP},
      {OP_READ,   32'h7FFF_FFFF, 1'b0, NO_RSP},
      {OP_WRITE,  32'h7FFF_FFFF, 1'b0, NO_RSP},
      {OP_UNUSED, 32'hFFFF_FFFF, 1'b0, NO_RSP},
      {OP_READ,   32'h0000_0001, 1'b0, NO_RSP},
      {OP_FLUSH,  32'h0000_0000, 1'b0, NO_RSP},
      {OP_WRITE,  32'hA5A5_A5A5, 1'b0, NO_RSP},
      {OP_WRITE,  32'h5A5A_5A5A, 1'b0, NO_RSP},
      {OP_FLUSH,  32'h0000_0000, 1'b0, NO_RSP},
      {OP_READ,   32'h5A5A_5A5A, 1'b0, NO_RSP},
      {OP_FLUSH,  32'h0000_0000, 1'b1, {1'b0, 6'd0, 1'b0, 1'b0, 32'h0, 1'b1}}
   };

   sector_cache_fifo_writeback #(
      .ENTRIES(N_SLOTS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_sector(req_sector),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_hit(rsp_hit),
      .rsp_slot(rsp_slot),
      .rsp_fill(rsp_fill),
      .rsp_writeback(rsp_writeback),
      .rsp_writeback_sector(rsp_writeback_sector),
      .rsp_last(rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic predict_request(input logic [OP_W-1:0] op,
                                  input logic [SECTOR_W-1:0] sec);
      int unsigned k, idx, n_dirty, n_sent;
      logic [SLOT_W-1:0] s;
      logic wb;
      if (op == OP_UNUSED)
         return;
      if (op == OP_FLUSH) begin
         n_dirty = 0;
         for (k = 0; k < cached; k++)
            if (dirty_mark[(oldest + k) % N_SLOTS])
               n_dirty++;
         if (n_dirty == 0) begin
            rsp_q.push_back({1'b0, 6'd0, 1'b0, 1'b0, 32'h0, 1'b1});
            return;
         end
         n_sent = 0;
         for (k = 0; k < cached; k++) begin
            idx = (oldest + k) % N_SLOTS;
            s = idx[SLOT_W-1:0];
            if (dirty_mark[idx]) begin
               n_sent++;
               rsp_q.push_back({1'b0, s, 1'b0, 1'b1, tag_mem[idx], n_sent == n_dirty});
               dirty_mark[idx] = 1'b0;
            end
         end
         return;
      end
      for (k = 0; k < cached; k++) begin
         if (tag_mem[k] == sec) begin
            s = k[SLOT_W-1:0];
            if (op == OP_WRITE)
               dirty_mark[k] = 1'b1;
            rsp_q.push_back({1'b1, s, 1'b0, 1'b0, 32'h0, 1'b1});
            return;
         end
      end
      if (cached < N_SLOTS) begin
         idx = cached;
         s = idx[SLOT_W-1:0];
         tag_mem[idx] = sec;
         dirty_mark[idx] = (op == OP_WRITE);
         cached++;
         rsp_q.push_back({1'b0, s, 1'b1, 1'b0, 32'h0, 1'b1});
      end else begin
         idx = oldest;
         s = idx[SLOT_W-1:0];
         wb = dirty_mark[idx];
         rsp_q.push_back({1'b0, s, 1'b1, wb, wb ? tag_mem[idx] : 32'h0, 1'b1});
         tag_mem[idx] = sec;
         dirty_mark[idx] = (op == OP_WRITE);
         oldest = (idx + 1) % N_SLOTS;
      end
   endtask

   // offers one transaction and returns at the edge that accepts it
   task automatic offer(input logic [OP_W-1:0] op, input logic [SECTOR_W-1:0] sec);
      while (!quiet && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_sector <= sec;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   initial begin : req_side
      int unsigned row, n, pick, k;
      logic [OP_W-1:0] op;
      logic [SECTOR_W-1:0] sec;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (row = 0; row < N_DIR; row++) begin
         offer(dir_tab[row].op, dir_tab[row].sector);
         predict_request(dir_tab[row].op, dir_tab[row].sector);
         if (dir_tab[row].typed)
            rsp_q[rsp_q.size() - 1] = dir_tab[row].want;
      end
      for (n = 0; n < RAND_ITEMS; n++) begin
         quiet = (n >= 200 && n < 300);
         if (n == 120) begin
            req_valid <= 1'b0;
            do
               @(posedge clock);
            while (rsp_q.size() != 0);
         end
         pick = $urandom_range(99);
         if (pick < 44)
            op = OP_READ;
         else if (pick < 86)
            op = OP_WRITE;
         else if (pick < 97)
            op = OP_FLUSH;
         else
            op = OP_UNUSED;
         pick = $urandom_range(99);
         k = $urandom_range(31);
         if (pick < 50 && recent_sectors.size() != 0)
            sec = recent_sectors[$urandom_range(recent_sectors.size() - 1)];
         else if (pick < 55)
            sec = (k < 16) ? 32'h0 : 32'hFFFF_FFFF;
         else if (pick < 60)
            sec = (k[0]) ? (32'h1 << k) : ~(32'h1 << k);
         else
            sec = $urandom;
         offer(op, sec);
         predict_request(op, sec);
         if (op == OP_READ || op == OP_WRITE) begin
            recent_sectors.push_back(sec);
            if (recent_sectors.size() > POOL_DEPTH)
               recent_sectors.delete(0);
         end
         if (n == 60)
            hold_rsp = 1'b1;
      end
      quiet = 1'b0;
      req_valid <= 1'b0;
      while (rsp_q.size() != 0)
         @(posedge clock);
      repeat (3 * N_SLOTS) @(posedge clock);
      if (mismatches == 0 && rsp_q.size() == 0)
         $display("sector_cache_fifo_writeback: match");
      else
         $display("sector_cache_fifo_writeback: mismatch");
      $finish;
   end

   initial begin : rsp_side
      int unsigned held;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_stall <= 1'b1;
            for (held = 0; held < HOLD_CYCLES; held++)
               @(posedge clock);
         end
         rsp_stall <= !quiet && ($urandom_range(99) < 37);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_rsp = {rsp_hit, rsp_slot, rsp_fill, rsp_writeback,
                    rsp_writeback_sector, rsp_last};
         if (rsp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t unexpected transaction: hit=%0b slot=%0d fill=%0b wb=%0b wbs=%h last=%0b",
                        $time, got_rsp.hit, got_rsp.slot, got_rsp.fill,
                        got_rsp.writeback, got_rsp.writeback_sector, got_rsp.last);
         end else begin
            want_rsp = rsp_q.pop_front();
            if (got_rsp.hit !== want_rsp.hit || got_rsp.slot !== want_rsp.slot ||
                got_rsp.fill !== want_rsp.fill ||
                got_rsp.writeback !== want_rsp.writeback ||
                got_rsp.writeback_sector !== want_rsp.writeback_sector ||
                got_rsp.last !== want_rsp.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t expected hit=%0b slot=%0d fill=%0b wb=%0b wbs=%h last=%0b",
                           $time, want_rsp.hit, want_rsp.slot, want_rsp.fill,
                           want_rsp.writeback, want_rsp.writeback_sector, want_rsp.last);
                  $display("%0t actual   hit=%0b slot=%0d fill=%0b wb=%0b wbs=%h last=%0b",
                           $time, got_rsp.hit, got_rsp.slot, got_rsp.fill,
                           got_rsp.writeback, got_rsp.writeback_sector, got_rsp.last);
               end
            end
         end
      end
   end

   initial begin : watchdog
      #8_000_000;
      $display("sector_cache_fifo_writeback: mismatch");
      $finish;
   end

endmodule
